FILE: hw/rtl/tensor_envelope_frame_checker_assert.svh
// Assertion macros used by the checker's top module.
`ifndef TENSOR_ENVELOPE_FRAME_CHECKER_ASSERT_SVH
`define TENSOR_ENVELOPE_FRAME_CHECKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TEFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TEFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tefc_pkg.sv
package tefc_pkg;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_PAY,
    PH_EHDR,
    PH_DIM,
    PH_DATA,
    PH_DONE,
    PH_DISC
  } phase_t;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_MAGIC    = 4'd1;
  localparam logic [3:0] ST_VERSION  = 4'd2;
  localparam logic [3:0] ST_RESERVED = 4'd3;
  localparam logic [3:0] ST_DTYPE    = 4'd4;
  localparam logic [3:0] ST_ORDER    = 4'd5;
  localparam logic [3:0] ST_RANK     = 4'd6;
  localparam logic [3:0] ST_DIMS     = 4'd7;
  localparam logic [3:0] ST_TRUNC    = 4'd8;
  localparam logic [3:0] ST_TRAIL    = 4'd9;

  localparam logic [2:0] ROLE_HDR  = 3'd0;
  localparam logic [2:0] ROLE_PAY  = 3'd1;
  localparam logic [2:0] ROLE_EHDR = 3'd2;
  localparam logic [2:0] ROLE_DIM  = 3'd3;
  localparam logic [2:0] ROLE_DATA = 3'd4;
  localparam logic [2:0] ROLE_DISC = 3'd5;

  localparam logic [1:0] REG_FRAME_KIND = 2'd0;
  localparam logic [1:0] REG_INT8_CODE  = 2'd1;
  localparam logic [1:0] REG_INT32_CODE = 2'd2;

  // Magic words as they arrive, first byte in the low lane.
  localparam logic [31:0] REQ_MAGIC = 32'h4B50_5243;
  localparam logic [31:0] RSP_MAGIC = 32'h5352_5243;

  localparam logic [4:0] REQ_HDR_LEN = 5'd24;
  localparam logic [4:0] RSP_HDR_LEN = 5'd12;
  localparam logic [7:0] VERSION    = 8'd1;

  typedef struct packed {
    logic       frame_kind;
    logic [7:0] int8_code;
    logic [7:0] int32_code;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] role;
    logic [7:0] entry_number;
    logic       frame_done;
    logic [3:0] status;
  } result_t;

endpackage

FILE: hw/rtl/tefc_parse.sv
module tefc_parse #(
  parameter int MAX_RANK = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tefc_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte_value,
  input  logic              in_last_byte,
  output logic              res_valid,
  output tefc_pkg::result_t res,
  input  logic              res_ready
);

  localparam int RANK_W = $clog2(MAX_RANK + 1);

  tefc_pkg::phase_t  phase_r, phase_nxt;
  logic [4:0]        off_r, off_nxt;
  logic [31:0]       shift_r, shift_nxt;
  logic [31:0]       pay_r, pay_nxt;
  logic [31:0]       tens_r, tens_nxt;
  logic [8:0]        eidx_r, eidx_nxt;
  logic              esz4_r, esz4_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [RANK_W-1:0] dimc_r, dimc_nxt;
  logic [63:0]       ecnt_r, ecnt_nxt;
  logic [95:0]       acc_r, acc_nxt;
  logic [63:0]       drem_r, drem_nxt;
  logic [3:0]        err_r, err_nxt;

  logic              acc_in;
  logic [7:0]        b;
  logic [31:0]       asm_w;
  logic [31:0]       magic_w;
  logic [7:0]        magic_b;
  logic [4:0]        hlen;
  logic              hdr_end;
  logic [31:0]       pay_v;
  logic [31:0]       tens_v;
  logic [71:0]       prod;
  logic [95:0]       acc_v;
  logic [RANK_W-1:0] dimc_inc;
  logic [63:0]       drem_dec;
  logic [31:0]       tens_dec;

  assign in_ready = res_ready;
  assign acc_in   = in_valid & res_ready;
  assign b        = in_byte_value;

  assign asm_w = (off_r[1:0] == 2'd0) ? {24'b0, b}
               : (shift_r | ({24'b0, b} << {off_r[1:0], 3'b000}));
  assign magic_w = cfg.frame_kind ? tefc_pkg::RSP_MAGIC : tefc_pkg::REQ_MAGIC;
  assign magic_b = 8'(magic_w >> {off_r[1:0], 3'b000});
  assign hlen    = cfg.frame_kind ? tefc_pkg::RSP_HDR_LEN : tefc_pkg::REQ_HDR_LEN;
  assign hdr_end = ({1'b0, off_r} + 6'd1) >= {1'b0, hlen};

  // One byte lane of the dim times the running count, added at its lane.
  assign prod     = ecnt_r * b;
  assign acc_v    = ((off_r[1:0] == 2'd0) ? 96'b0 : acc_r)
                  + (({24'b0, prod}) << {off_r[1:0], 3'b000});
  assign dimc_inc = dimc_r + 1'b1;
  assign drem_dec = drem_r - 64'd1;
  assign tens_dec = tens_r - 32'd1;

  always_comb begin
    phase_nxt = phase_r;
    off_nxt   = off_r;
    shift_nxt = shift_r;
    pay_nxt   = pay_r;
    tens_nxt  = tens_r;
    eidx_nxt  = eidx_r;
    esz4_nxt  = esz4_r;
    rank_nxt  = rank_r;
    dimc_nxt  = dimc_r;
    ecnt_nxt  = ecnt_r;
    acc_nxt   = acc_r;
    drem_nxt  = drem_r;
    err_nxt   = err_r;
    pay_v     = pay_r;
    tens_v    = tens_r;
    unique case (phase_r)
      tefc_pkg::PH_HDR: begin
        shift_nxt = asm_w;
        if (off_r < 5'd4) begin
          if (b != magic_b) begin
            err_nxt = tefc_pkg::ST_MAGIC;
          end
        end else if (off_r == 5'd4) begin
          if (b != tefc_pkg::VERSION) begin
            err_nxt = tefc_pkg::ST_VERSION;
          end
        end else if (off_r == 5'd5) begin
          if (b != 8'd0) begin
            err_nxt = tefc_pkg::ST_VERSION;
          end
        end else if (!cfg.frame_kind) begin
          if ((off_r == 5'd6 || off_r == 5'd7 || off_r == 5'd18 || off_r == 5'd19)
              && b != 8'd0) begin
            err_nxt = tefc_pkg::ST_RESERVED;
          end else if (off_r == 5'd17 && b != cfg.int8_code && b != cfg.int32_code) begin
            err_nxt = tefc_pkg::ST_DTYPE;
          end
          if (off_r == 5'd11) pay_v = asm_w;
          if (off_r == 5'd15) tens_v = asm_w;
        end else begin
          if (off_r == 5'd11) tens_v = asm_w;
        end
        pay_nxt  = pay_v;
        tens_nxt = tens_v;
        if (err_nxt != tefc_pkg::ST_OK) begin
          phase_nxt = tefc_pkg::PH_DISC;
        end else if (hdr_end) begin
          off_nxt = 5'd0;
          if (!cfg.frame_kind && pay_v != 32'd0) begin
            phase_nxt = tefc_pkg::PH_PAY;
          end else begin
            phase_nxt = (tens_v == 32'd0) ? tefc_pkg::PH_DONE : tefc_pkg::PH_EHDR;
          end
        end else begin
          off_nxt = off_r + 5'd1;
        end
      end
      tefc_pkg::PH_PAY: begin
        pay_nxt = pay_r - 32'd1;
        if (pay_nxt == 32'd0) begin
          off_nxt   = 5'd0;
          phase_nxt = (tens_r == 32'd0) ? tefc_pkg::PH_DONE : tefc_pkg::PH_EHDR;
        end
      end
      tefc_pkg::PH_EHDR: begin
        off_nxt = off_r + 5'd1;
        case (off_r[1:0])
          2'd0: begin
            if (eidx_r[8] || b != eidx_r[7:0]) err_nxt = tefc_pkg::ST_ORDER;
          end
          2'd1: begin
            if (b == cfg.int8_code) esz4_nxt = 1'b0;
            else if (b == cfg.int32_code) esz4_nxt = 1'b1;
            else err_nxt = tefc_pkg::ST_DTYPE;
          end
          2'd2: begin
            if (b < 8'd1 || b > 8'(MAX_RANK)) err_nxt = tefc_pkg::ST_RANK;
            rank_nxt = b[RANK_W-1:0];
          end
          default: begin
            if (b != 8'd0) begin
              err_nxt = tefc_pkg::ST_RESERVED;
            end else begin
              phase_nxt = tefc_pkg::PH_DIM;
              off_nxt   = 5'd0;
              dimc_nxt  = '0;
              ecnt_nxt  = 64'd1;
            end
          end
        endcase
        if (err_nxt != tefc_pkg::ST_OK) phase_nxt = tefc_pkg::PH_DISC;
      end
      tefc_pkg::PH_DIM: begin
        shift_nxt = asm_w;
        acc_nxt   = acc_v;
        if (off_r[1:0] != 2'd3) begin
          off_nxt = {3'b000, off_r[1:0]} + 5'd1;
        end else if (asm_w == 32'd0 || acc_v[95:64] != 32'd0) begin
          err_nxt   = tefc_pkg::ST_DIMS;
          phase_nxt = tefc_pkg::PH_DISC;
        end else begin
          ecnt_nxt = acc_v[63:0];
          dimc_nxt = dimc_inc;
          off_nxt  = 5'd0;
          if (dimc_inc >= rank_r) begin
            if (esz4_r && acc_v[63:62] != 2'b00) begin
              err_nxt   = tefc_pkg::ST_DIMS;
              phase_nxt = tefc_pkg::PH_DISC;
            end else begin
              drem_nxt  = esz4_r ? {acc_v[61:0], 2'b00} : acc_v[63:0];
              phase_nxt = tefc_pkg::PH_DATA;
            end
          end
        end
      end
      tefc_pkg::PH_DATA: begin
        drem_nxt = drem_dec;
        if (drem_dec == 64'd0) begin
          tens_nxt  = tens_dec;
          if (!eidx_r[8]) eidx_nxt = eidx_r + 9'd1;
          off_nxt   = 5'd0;
          phase_nxt = (tens_dec == 32'd0) ? tefc_pkg::PH_DONE : tefc_pkg::PH_EHDR;
        end
      end
      tefc_pkg::PH_DONE: begin
        err_nxt   = tefc_pkg::ST_TRAIL;
        phase_nxt = tefc_pkg::PH_DISC;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.byte_out     = b;
    res.frame_done   = in_last_byte;
    res.entry_number = 8'd0;
    res.role         = tefc_pkg::ROLE_DISC;
    unique case (phase_r)
      tefc_pkg::PH_HDR:  res.role = tefc_pkg::ROLE_HDR;
      tefc_pkg::PH_PAY:  res.role = tefc_pkg::ROLE_PAY;
      tefc_pkg::PH_EHDR: res.role = tefc_pkg::ROLE_EHDR;
      tefc_pkg::PH_DIM:  res.role = tefc_pkg::ROLE_DIM;
      tefc_pkg::PH_DATA: res.role = tefc_pkg::ROLE_DATA;
      default:           res.role = tefc_pkg::ROLE_DISC;
    endcase
    if (phase_r == tefc_pkg::PH_EHDR || phase_r == tefc_pkg::PH_DIM
        || phase_r == tefc_pkg::PH_DATA) begin
      res.entry_number = eidx_r[8] ? 8'hFF : eidx_r[7:0];
    end
    res.status = err_nxt;
    if (in_last_byte && err_nxt == tefc_pkg::ST_OK && phase_nxt != tefc_pkg::PH_DONE) begin
      res.status = tefc_pkg::ST_TRUNC;
    end
    res_valid = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc_in && in_last_byte)) begin
      phase_r <= tefc_pkg::PH_HDR;
      off_r   <= 5'd0;
      shift_r <= 32'd0;
      pay_r   <= 32'd0;
      tens_r  <= 32'd0;
      eidx_r  <= 9'd0;
      esz4_r  <= 1'b0;
      rank_r  <= '0;
      dimc_r  <= '0;
      ecnt_r  <= 64'd1;
      acc_r   <= 96'd0;
      drem_r  <= 64'd0;
      err_r   <= tefc_pkg::ST_OK;
    end else if (acc_in) begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      shift_r <= shift_nxt;
      pay_r   <= pay_nxt;
      tens_r  <= tens_nxt;
      eidx_r  <= eidx_nxt;
      esz4_r  <= esz4_nxt;
      rank_r  <= rank_nxt;
      dimc_r  <= dimc_nxt;
      ecnt_r  <= ecnt_nxt;
      acc_r   <= acc_nxt;
      drem_r  <= drem_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

FILE: hw/rtl/tefc_queue.sv
module tefc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  tefc_pkg::result_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output tefc_pkg::result_t rd_data
);

  tefc_pkg::result_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: hw/rtl/tensor_envelope_frame_checker.sv
// Tensor envelope checker: one frame byte in per item, one tagged byte out per item.
// Input channel in_valid/in_ready carries in_byte_value and in_last_byte.
// Result channel out_valid/out_ready carries the byte back with its role,
// entry number, frame_done mark and the running status (final on frame_done).
// Configuration: cfg_we writes cfg_wdata into register cfg_index at once
// (0 frame_kind, 1 int8_code, 2 int32_code); write only while no frame is busy.
// A result is shown in the cycle after its item is taken.
// Throughput: one byte per cycle while the queue has room; the parser closes
// each byte combinationally, its slowest step a 64x8 partial product per dim byte.
// A two-entry queue sits between parser and output, so input is taken
// while a result waits; when out_ready stays low the queue fills and
// in_ready drops after two held results, with nothing lost.
// Reset (rst_n low, synchronous) empties the queue, restores the registers
// to request form with codes 0 and 1, and starts a fresh frame. After the
// byte marked last the frame state returns to its start by itself.
module tensor_envelope_frame_checker #(
  parameter int MAX_RANK = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_value,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte_out,
  output logic [2:0] out_role,
  output logic [7:0] out_entry_number,
  output logic       out_frame_done,
  output logic [3:0] out_status
);

`include "tensor_envelope_frame_checker_assert.svh"

  tefc_pkg::cfg_t    cfg_r;
  tefc_pkg::result_t res, q_out;
  logic              res_valid, res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_kind <= 1'b0;
      cfg_r.int8_code  <= 8'd0;
      cfg_r.int32_code <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        tefc_pkg::REG_FRAME_KIND: cfg_r.frame_kind <= cfg_wdata[0];
        tefc_pkg::REG_INT8_CODE:  cfg_r.int8_code  <= cfg_wdata;
        tefc_pkg::REG_INT32_CODE: cfg_r.int32_code <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  tefc_parse #(
    .MAX_RANK(MAX_RANK)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte_value(in_byte_value),
    .in_last_byte (in_last_byte),
    .res_valid    (res_valid),
    .res          (res),
    .res_ready    (res_ready)
  );

  tefc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(res_valid),
    .wr_ready(res_ready),
    .wr_data (res),
    .rd_valid(out_valid),
    .rd_ready(out_ready),
    .rd_data (q_out)
  );

  assign out_byte_out     = q_out.byte_out;
  assign out_role         = q_out.role;
  assign out_entry_number = q_out.entry_number;
  assign out_frame_done   = q_out.frame_done;
  assign out_status       = q_out.status;

  `TEFC_ASSERT_IMP(a_full_has_out, !in_ready, out_valid, "queue full with no result shown")
  `TEFC_ASSERT_IMP(a_disc_has_err, out_valid && out_role == tefc_pkg::ROLE_DISC,
    out_status != tefc_pkg::ST_OK, "discarded byte with ok status")
  `TEFC_ASSERT_IMP(a_hdr_no_entry,
    out_valid && (out_role == tefc_pkg::ROLE_HDR || out_role == tefc_pkg::ROLE_PAY),
    out_entry_number == 8'd0, "entry number on header or payload byte")
  `TEFC_ASSERT_NXT(a_take_shows, in_valid && in_ready, out_valid, "taken item not shown")

endmodule

FILE: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RANK = 4;
  localparam int WATCHDOG_LIMIT = 5000;

  class envelope_scoreboard;
    // register copy
    logic       kind;
    logic [7:0] code8;
    logic [7:0] code32;
    // frame state
    tefc_pkg::phase_t ph;
    logic [4:0]  fofs;
    logic [31:0] word;
    logic [31:0] pay_left;
    logic [31:0] tens_left;
    logic [8:0]  want_idx;
    logic [2:0]  esize;
    logic [2:0]  rank;
    logic [2:0]  dims_seen;
    logic [63:0] elems;
    logic [63:0] data_left;
    logic [3:0]  err;

    tefc_pkg::result_t pending[$];
    int      mismatches;

    function new();
      kind = 1'b0;
      code8 = 8'd0;
      code32 = 8'd1;
      mismatches = 0;
      clear_frame();
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        tefc_pkg::REG_FRAME_KIND: kind = val[0];
        tefc_pkg::REG_INT8_CODE: code8 = val;
        tefc_pkg::REG_INT32_CODE: code32 = val;
        default: ;
      endcase
    endfunction

    function void clear_frame();
      ph = tefc_pkg::PH_HDR;
      fofs = '0;
      word = '0;
      pay_left = '0;
      tens_left = '0;
      want_idx = '0;
      esize = '0;
      rank = '0;
      dims_seen = '0;
      elems = 64'd1;
      data_left = '0;
      err = tefc_pkg::ST_OK;
    endfunction

    function void fail(logic [3:0] code);
      err = code;
      ph = tefc_pkg::PH_DISC;
    endfunction

    function void next_entry();
      fofs = '0;
      ph = (tens_left == 0) ? tefc_pkg::PH_DONE : tefc_pkg::PH_EHDR;
    endfunction

    function void gather(logic [7:0] b, logic [1:0] pos);
      if (pos == 0) word = {24'd0, b};
      else word = word | ({24'd0, b} << (8 * pos));
    endfunction

    function void header_byte(logic [7:0] b);
      logic [4:0]  off;
      logic [31:0] magic;
      int          hlen;
      off = fofs;
      magic = kind ? tefc_pkg::RSP_MAGIC : tefc_pkg::REQ_MAGIC;
      hlen = int'(kind ? tefc_pkg::RSP_HDR_LEN : tefc_pkg::REQ_HDR_LEN);
      gather(b, off[1:0]);
      if (off < 4) begin
        if (b != magic[8*off +: 8]) begin
          fail(tefc_pkg::ST_MAGIC);
          return;
        end
      end else if (off == 4) begin
        if (b != tefc_pkg::VERSION) begin
          fail(tefc_pkg::ST_VERSION);
          return;
        end
      end else if (off == 5) begin
        if (b != 0) begin
          fail(tefc_pkg::ST_VERSION);
          return;
        end
      end else if (!kind) begin
        if ((off == 6 || off == 7 || off == 18 || off == 19) && b != 0) begin
          fail(tefc_pkg::ST_RESERVED);
          return;
        end
        if (off == 11) pay_left = word;
        if (off == 15) tens_left = word;
        if (off == 17 && b != code8 && b != code32) begin
          fail(tefc_pkg::ST_DTYPE);
          return;
        end
      end else if (off == 11) begin
        tens_left = word;
      end
      if (int'(off) + 1 >= hlen) begin
        if (!kind && pay_left != 0) begin
          ph = tefc_pkg::PH_PAY;
          fofs = '0;
        end else begin
          next_entry();
        end
      end else begin
        fofs = off + 5'd1;
      end
    endfunction

    function void entry_header_byte(logic [7:0] b);
      case (fofs)
        0: if (want_idx > 255 || {1'b0, b} != want_idx) begin
          fail(tefc_pkg::ST_ORDER);
          return;
        end
        1: begin
          if (b == code8) esize = 3'd1;
          else if (b == code32) esize = 3'd4;
          else begin
            fail(tefc_pkg::ST_DTYPE);
            return;
          end
        end
        2: begin
          if (b < 1 || b > MAX_RANK) begin
            fail(tefc_pkg::ST_RANK);
            return;
          end
          rank = b[2:0];
        end
        default: begin
          if (b != 0) begin
            fail(tefc_pkg::ST_RESERVED);
            return;
          end
          ph = tefc_pkg::PH_DIM;
          fofs = '0;
          dims_seen = '0;
          elems = 64'd1;
          return;
        end
      endcase
      fofs = fofs + 5'd1;
    endfunction

    function void dim_byte(logic [7:0] b);
      logic [1:0]  off;
      logic [63:0] es;
      off = fofs[1:0];
      gather(b, off);
      if (off != 2'd3) begin
        fofs = {3'b000, off} + 5'd1;
        return;
      end
      if (word == 0 || elems > 64'hFFFF_FFFF_FFFF_FFFF / {32'd0, word}) begin
        fail(tefc_pkg::ST_DIMS);
        return;
      end
      elems = elems * {32'd0, word};
      dims_seen = dims_seen + 3'd1;
      fofs = '0;
      if (dims_seen >= rank) begin
        es = (esize == 3'd4) ? 64'd4 : 64'd1;
        if (elems > 64'hFFFF_FFFF_FFFF_FFFF / es) begin
          fail(tefc_pkg::ST_DIMS);
          return;
        end
        data_left = elems * es;
        ph = tefc_pkg::PH_DATA;
      end
    endfunction

    function tefc_pkg::result_t predict_byte(logic [7:0] b, logic last);
      tefc_pkg::result_t r;
      logic [7:0] ent;
      r.role = tefc_pkg::ROLE_DISC;
      ent = (want_idx > 255) ? 8'd255 : want_idx[7:0];
      r.entry_number = 8'd0;
      case (ph)
        tefc_pkg::PH_HDR: begin
          r.role = tefc_pkg::ROLE_HDR;
          header_byte(b);
        end
        tefc_pkg::PH_PAY: begin
          r.role = tefc_pkg::ROLE_PAY;
          pay_left = pay_left - 32'd1;
          if (pay_left == 0) next_entry();
        end
        tefc_pkg::PH_EHDR: begin
          r.role = tefc_pkg::ROLE_EHDR;
          r.entry_number = ent;
          entry_header_byte(b);
        end
        tefc_pkg::PH_DIM: begin
          r.role = tefc_pkg::ROLE_DIM;
          r.entry_number = ent;
          dim_byte(b);
        end
        tefc_pkg::PH_DATA: begin
          r.role = tefc_pkg::ROLE_DATA;
          r.entry_number = ent;
          data_left = data_left - 64'd1;
          if (data_left == 0) begin
            tens_left = tens_left - 32'd1;
            if (want_idx < 256) want_idx = want_idx + 9'd1;
            next_entry();
          end
        end
        tefc_pkg::PH_DONE: fail(tefc_pkg::ST_TRAIL);
        default: ;
      endcase
      r.byte_out = b;
      r.frame_done = last;
      r.status = err;
      if (last && err == tefc_pkg::ST_OK && ph != tefc_pkg::PH_DONE) r.status = tefc_pkg::ST_TRUNC;
      if (last) clear_frame();
      return r;
    endfunction

    function void note_input(logic [7:0] b, logic last);
      pending = {pending, predict_byte(b, last)};
    endfunction

    function void check_result(tefc_pkg::result_t got);
      tefc_pkg::result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.byte_out !== want.byte_out || got.role !== want.role ||
          got.entry_number !== want.entry_number ||
          got.frame_done !== want.frame_done || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte_value;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte_out;
  logic [2:0] out_role;
  logic [7:0] out_entry_number;
  logic       out_frame_done;
  logic [3:0] out_status;

  tensor_envelope_frame_checker #(.MAX_RANK(MAX_RANK)) i_dut (.*);

  envelope_scoreboard sb = new();
  int  snd_idle = 9;
  int  rcv_idle = 49;
  int  bytes_sent = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  bit  hold_req = 0;
  bit  seen_accept = 0;
  logic [7:0] frame[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(negedge clk) begin
    seen_accept = 0;
    if (rst_n && in_valid && in_ready) seen_accept = 1;
    if (rst_n && out_valid && out_ready) begin
      seen_accept = 1;
      sb.check_result('{out_byte_out, out_role, out_entry_number, out_frame_done,
                        out_status});
    end
  end

  always @(posedge clk) begin
    if (seen_accept) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= b;
    in_last_byte <= last;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    sb.note_input(b, last);
    bytes_sent++;
  endtask

  // send the queued bytes; mark the final one last unless told otherwise
  task automatic send_frame(bit mark_last = 1);
    foreach (frame[i]) send_byte(frame[i], mark_last && i == frame.size() - 1);
    frame.delete();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic void add_byte(logic [7:0] b);
    frame = {frame, b};
  endfunction

  function automatic void put32(logic [31:0] w);
    for (int i = 0; i < 4; i++) add_byte(w[8*i +: 8]);
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic void add_header(logic kind, int n_tens);
    logic [31:0] pay;
    pay = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(1, 6);
    put32(kind ? tefc_pkg::RSP_MAGIC : tefc_pkg::REQ_MAGIC);
    add_byte(tefc_pkg::VERSION);
    add_byte(8'd0);
    if (kind) begin
      add_byte(any_byte());
      add_byte(any_byte());
      put32(32'(n_tens));
    end else begin
      add_byte(8'd0);
      add_byte(8'd0);
      put32(pay);
      put32(32'(n_tens));
      add_byte(any_byte());
      add_byte($urandom_range(1) ? sb.code8 : sb.code32);
      add_byte(8'd0);
      add_byte(8'd0);
      put32($urandom);
      for (int i = 0; i < pay; i++) add_byte(any_byte());
    end
  endfunction

  function automatic void add_entry(int idx, bit huge);
    logic [7:0] code;
    int rk;
    int cnt;
    int dim;
    code = $urandom_range(1) ? sb.code8 : sb.code32;
    rk = $urandom_range(1, MAX_RANK);
    cnt = (code == sb.code8) ? 1 : 4;
    add_byte(8'(idx));
    add_byte(code);
    add_byte(8'(rk));
    add_byte(8'd0);
    for (int d = 0; d < rk; d++) begin
      if (huge) begin
        put32($urandom_range(1) ? 32'hFFFF_FFFF : 32'h8000_0000);
      end else begin
        dim = (rk > 2) ? $urandom_range(1, 2) : $urandom_range(1, 4);
        put32(32'(dim));
        cnt = cnt * dim;
      end
    end
    if (!huge) for (int i = 0; i < cnt; i++) add_byte(any_byte());
  endfunction

  // random bytes, or a frame with random content that may be broken on purpose
  task automatic random_frame();
    int n;
    int pos;
    int mode;
    bit mark;
    mark = 1;
    mode = $urandom_range(99);
    if (mode < 8) begin
      repeat ($urandom_range(1, 30)) add_byte(any_byte());
    end else begin
      n = $urandom_range(3);
      add_header(sb.kind, n);
      for (int e = 0; e < n; e++) add_entry(e, $urandom_range(29) == 0);
      if (mode < 20) begin
        pos = $urandom_range(frame.size() - 1);
        frame[pos] = any_byte();
      end else if (mode < 28) begin
        frame = frame[0:$urandom_range(frame.size() - 1)];
      end else if (mode < 34) begin
        repeat ($urandom_range(1, 3)) add_byte(any_byte());
      end else if (mode < 37) begin
        mark = 0;
      end
    end
    send_frame(mark);
  endtask

  initial begin
    logic [7:0] codes8[6] = '{8'd0, 8'd255, 8'd7, 8'd42, 8'd5, 8'd128};
    logic [7:0] codes32[6] = '{8'd1, 8'd255, 8'd0, 8'd200, 8'd5, 8'd127};
    int step;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = tefc_pkg::REG_FRAME_KIND;
    cfg_wdata = 8'd0;
    in_valid = 1'b0;
    in_byte_value = 8'd0;
    in_last_byte = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short directed frames: bad magic, bad version, bad reserved byte, two lone bytes
    put32(tefc_pkg::REQ_MAGIC ^ 32'h0000_0100);
    send_frame();
    put32(tefc_pkg::REQ_MAGIC);
    add_byte(8'd2);
    send_frame();
    put32(tefc_pkg::REQ_MAGIC);
    add_byte(tefc_pkg::VERSION);
    add_byte(8'd0);
    add_byte(8'h80);
    send_frame();
    add_byte(8'hFF);
    send_frame();
    add_byte(8'h00);
    send_frame();

    step = 0;
    while (bytes_sent < 2000) begin
      if (bytes_sent < 700) begin
        snd_idle = 9;
        rcv_idle = 49;
      end else if (bytes_sent < 1400) begin
        snd_idle = 49;
        rcv_idle = 9;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      write_reg(tefc_pkg::REG_FRAME_KIND, 8'(step % 2));
      write_reg(tefc_pkg::REG_INT8_CODE, (step < 6) ? codes8[step] : any_byte());
      write_reg(tefc_pkg::REG_INT32_CODE, (step < 6) ? codes32[step] : any_byte());
      if (step == 1) hold_req = 1;
      if (step == 2) begin
        // header length changes under a frame already past 12 bytes
        add_header(1'b0, 0);
        frame = frame[0:13];
        send_frame(0);
        write_reg(tefc_pkg::REG_FRAME_KIND, 8'd1);
        repeat (4) add_byte(any_byte());
        send_frame();
      end
      repeat (4) random_frame();
      step++;
    end
    drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/tefc_pkg.sv
hw/rtl/tefc_parse.sv
hw/rtl/tefc_queue.sv
hw/rtl/tensor_envelope_frame_checker.sv
verif/tb_top.sv
